>>> rtl/pdd_pkg.sv
`timescale 1ns / 1ps
// Package for the priority dispatcher: payload structs, queue entry and
// candidate types, status, mode and register index codes. No dependencies.
package pdd_pkg;

    // Field widths
    localparam int unsigned ID_W    = 16;
    localparam int unsigned PRIO_W  = 8;
    localparam int unsigned BURST_W = 16;
    localparam int unsigned UNIT_W  = 24;
    localparam int unsigned PROD_W  = 40;
    localparam int unsigned SUM_W   = 48;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    // Actions
    localparam logic ACT_ADD      = 1'b0;
    localparam logic ACT_DISPATCH = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Power modes
    localparam logic [1:0] MODE_HIGH     = 2'd0;
    localparam logic [1:0] MODE_BALANCED = 2'd1;
    localparam logic [1:0] MODE_SAVING   = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MED_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TU_HIGH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TU_BAL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TU_SAVE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EU_HIGH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EU_BAL     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_EU_SAVE    = 3'd7;

    typedef struct packed {
        logic               action;
        logic [ID_W-1:0]    task_id;
        logic [PRIO_W-1:0]  task_priority;
        logic [BURST_W-1:0] burst_units;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic               dispatched;
        logic [ID_W-1:0]    out_task_id;
        logic [PRIO_W-1:0]  out_priority;
        logic [BURST_W-1:0] out_burst;
        logic [1:0]         power_mode;
        logic [PROD_W-1:0]  exec_time;
        logic [PROD_W-1:0]  energy;
        logic [SUM_W-1:0]   elapsed_total;
        logic [SUM_W-1:0]   energy_total;
    } t_out;

    // One queued task
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
    } t_entry;

    // Control from the sequencer to one cell
    typedef struct packed {
        logic occupied;
        logic write;
        logic shift;
    } t_cell_ctrl;

    // Running minimum that travels down the chain
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_cand;

endpackage

>>> rtl/pdd_cell.sv
`timescale 1ns / 1ps
// One queue cell: holds one task, takes a new task or its upper neighbor's
// task, and passes a registered running minimum toward cell 0. Uses pdd_pkg.
module pdd_cell #(
    parameter int unsigned IDX_W = 4,
    parameter int unsigned INDEX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pdd_pkg::t_cell_ctrl i_ctrl,
    input  pdd_pkg::t_entry     i_wr_entry,
    input  pdd_pkg::t_entry     i_nb_entry,
    input  pdd_pkg::t_cand      i_cand,
    input  logic [IDX_W-1:0]    i_cand_idx,
    output pdd_pkg::t_entry     o_entry,
    output pdd_pkg::t_cand      o_cand,
    output logic [IDX_W-1:0]    o_cand_idx
);

    pdd_pkg::t_entry  r_entry;
    pdd_pkg::t_cand   r_cand;
    logic [IDX_W-1:0] r_cand_idx;
    logic             take_own;

    // Stored task: new write, or shift down from the neighbor
    always_ff @(posedge i_clk) begin
        if (i_ctrl.write) begin
            r_entry <= i_wr_entry;
        end else if (i_ctrl.shift) begin
            r_entry <= i_nb_entry;
        end
    end

    // Ties go to the lower index, so the earlier arrival wins
    assign take_own = i_ctrl.occupied &&
                      (!i_cand.valid || (r_entry.prio <= i_cand.entry.prio));

    // Running minimum stage; only the valid flag is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand.valid <= 1'b0;
        end else begin
            r_cand.valid <= take_own || i_cand.valid;
        end
        if (take_own) begin
            r_cand.entry <= r_entry;
            r_cand_idx   <= IDX_W'(INDEX);
        end else begin
            r_cand.entry <= i_cand.entry;
            r_cand_idx   <= i_cand_idx;
        end
    end

    assign o_entry    = r_entry;
    assign o_cand     = r_cand;
    assign o_cand_idx = r_cand_idx;

endmodule

>>> rtl/priority_dvfs_task_dispatcher.sv
`timescale 1ns / 1ps
// Top level of the priority dispatcher: sequencer, configuration registers,
// cost multipliers and totals around a chain of pdd_cell. Uses pdd_pkg.
//
// Tasks sit in a chain of QUEUE_DEPTH cells in arrival order. An add, a
// dropped add or a dispatch on an empty queue goes from idle to the final
// step. A dispatch first scans: the minimum priority ripples one cell per
// cycle from the top of the chain down to cell 0; then the remove step takes
// out the task (all cells above it shift down at once) and multiplies burst
// by the mode's time and energy units, and the final step adds to the
// saturating totals and loads the result register. A new item is taken only
// with the sequencer idle; a result left in the output register stalls the
// final step until it is taken.
module priority_dvfs_task_dispatcher #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  pdd_pkg::t_in                        i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output pdd_pkg::t_out                       o_out_data,
    input  logic                                i_cfg_we,
    input  logic [pdd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pdd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_REMOVE = 2'd2;
    localparam logic [1:0] S_FIN    = 2'd3;

    // Configuration registers
    logic [pdd_pkg::PRIO_W-1:0] r_high_limit, r_med_limit;
    logic [pdd_pkg::UNIT_W-1:0] r_tu_high, r_tu_bal, r_tu_save;
    logic [pdd_pkg::UNIT_W-1:0] r_eu_high, r_eu_bal, r_eu_save;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_limit <= 8'd2;
            r_med_limit  <= 8'd5;
            r_tu_high    <= 24'd26214;
            r_tu_bal     <= 24'd43691;
            r_tu_save    <= 24'd81920;
            r_eu_high    <= 24'd131072;
            r_eu_bal     <= 24'd131072;
            r_eu_save    <= 24'd122880;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pdd_pkg::REG_HIGH_LIMIT: r_high_limit <= i_cfg_data[pdd_pkg::PRIO_W-1:0];
                pdd_pkg::REG_MED_LIMIT:  r_med_limit  <= i_cfg_data[pdd_pkg::PRIO_W-1:0];
                pdd_pkg::REG_TU_HIGH:    r_tu_high    <= i_cfg_data;
                pdd_pkg::REG_TU_BAL:     r_tu_bal     <= i_cfg_data;
                pdd_pkg::REG_TU_SAVE:    r_tu_save    <= i_cfg_data;
                pdd_pkg::REG_EU_HIGH:    r_eu_high    <= i_cfg_data;
                pdd_pkg::REG_EU_BAL:     r_eu_bal     <= i_cfg_data;
                pdd_pkg::REG_EU_SAVE:    r_eu_save    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and control state
    logic [1:0]       r_state;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_scan_cnt;
    logic [1:0]       r_mode;
    logic [pdd_pkg::SUM_W-1:0] r_time_sum, r_energy_sum;
    logic             r_out_valid;
    pdd_pkg::t_out    r_out;

    // Per-item result held until the final step
    logic [1:0]                  r_status;
    logic                        r_disp;
    pdd_pkg::t_entry             r_task;
    logic [pdd_pkg::PROD_W-1:0]  r_exec, r_eng;

    logic in_xfer, add_go, out_free, fin_go;
    logic [IDX_W-1:0] best_idx;
    pdd_pkg::t_cand   best;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign add_go     = in_xfer && (i_in_data.action == pdd_pkg::ACT_ADD) &&
                        (r_count < CNT_W'(QUEUE_DEPTH));
    assign out_free   = !r_out_valid || i_out_ready;
    assign fin_go     = (r_state == S_FIN) && out_free;

    // Chain of cells
    pdd_pkg::t_cell_ctrl cell_ctrl [QUEUE_DEPTH];
    pdd_pkg::t_entry     cell_entry [QUEUE_DEPTH];
    pdd_pkg::t_cand      cell_cand [QUEUE_DEPTH];
    logic [IDX_W-1:0]    cell_idx [QUEUE_DEPTH];
    pdd_pkg::t_entry     wr_entry;

    assign wr_entry.id    = i_in_data.task_id;
    assign wr_entry.prio  = i_in_data.task_priority;
    assign wr_entry.burst = i_in_data.burst_units;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        pdd_pkg::t_entry  nb_entry;
        pdd_pkg::t_cand   cand_in;
        logic [IDX_W-1:0] idx_in;

        // Top cell sees an empty candidate and no neighbor
        if (g == QUEUE_DEPTH - 1) begin : g_top
            assign nb_entry = cell_entry[g];
            assign cand_in  = '0;
            assign idx_in   = '0;
        end else begin : g_mid
            assign nb_entry = cell_entry[g+1];
            assign cand_in  = cell_cand[g+1];
            assign idx_in   = cell_idx[g+1];
        end

        assign cell_ctrl[g].occupied = (CNT_W'(g) < r_count);
        assign cell_ctrl[g].write    = add_go && (CNT_W'(g) == r_count);
        assign cell_ctrl[g].shift    = (r_state == S_REMOVE) && (IDX_W'(g) >= best_idx) &&
                                       (CNT_W'(g + 1) < r_count);

        pdd_cell #(
            .IDX_W (IDX_W),
            .INDEX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (cell_ctrl[g]),
            .i_wr_entry (wr_entry),
            .i_nb_entry (nb_entry),
            .i_cand     (cand_in),
            .i_cand_idx (idx_in),
            .o_entry    (cell_entry[g]),
            .o_cand     (cell_cand[g]),
            .o_cand_idx (cell_idx[g])
        );
    end

    assign best     = cell_cand[0];
    assign best_idx = cell_idx[0];

    // Mode and unit choice for the removed task
    logic [1:0]                 sel_mode;
    logic [pdd_pkg::UNIT_W-1:0] sel_tu, sel_eu;

    always_comb begin
        if (best.entry.prio < r_high_limit) begin
            sel_mode = pdd_pkg::MODE_HIGH;
            sel_tu   = r_tu_high;
            sel_eu   = r_eu_high;
        end else if (best.entry.prio < r_med_limit) begin
            sel_mode = pdd_pkg::MODE_BALANCED;
            sel_tu   = r_tu_bal;
            sel_eu   = r_eu_bal;
        end else begin
            sel_mode = pdd_pkg::MODE_SAVING;
            sel_tu   = r_tu_save;
            sel_eu   = r_eu_save;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_scan_cnt <= '0;
            r_mode     <= pdd_pkg::MODE_BALANCED;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_scan_cnt <= '0;
                        if (add_go) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        if ((i_in_data.action == pdd_pkg::ACT_DISPATCH) && (r_count != '0)) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_SCAN: begin
                    r_scan_cnt <= r_scan_cnt + IDX_W'(1);
                    if (r_scan_cnt == IDX_W'(QUEUE_DEPTH - 1)) begin
                        r_state <= S_REMOVE;
                    end
                end
                S_REMOVE: begin
                    r_count <= r_count - CNT_W'(1);
                    r_mode  <= sel_mode;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Per-item result fields and products
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_disp <= 1'b0;
            r_task <= '0;
            r_exec <= '0;
            r_eng  <= '0;
            if (i_in_data.action == pdd_pkg::ACT_ADD) begin
                r_status <= add_go ? pdd_pkg::ST_OK : pdd_pkg::ST_FULL;
            end else begin
                r_status <= (r_count == '0) ? pdd_pkg::ST_EMPTY : pdd_pkg::ST_OK;
            end
        end else if (r_state == S_REMOVE) begin
            r_disp <= 1'b1;
            r_task <= best.entry;
            r_exec <= pdd_pkg::PROD_W'(best.entry.burst) * pdd_pkg::PROD_W'(sel_tu);
            r_eng  <= pdd_pkg::PROD_W'(best.entry.burst) * pdd_pkg::PROD_W'(sel_eu);
        end
    end

    // Saturating totals
    logic [pdd_pkg::SUM_W:0]   time_add, energy_add;
    logic [pdd_pkg::SUM_W-1:0] n_time_sum, n_energy_sum;

    assign time_add     = {1'b0, r_time_sum} + (pdd_pkg::SUM_W + 1)'(r_exec);
    assign energy_add   = {1'b0, r_energy_sum} + (pdd_pkg::SUM_W + 1)'(r_eng);
    assign n_time_sum   = time_add[pdd_pkg::SUM_W] ? '1 : time_add[pdd_pkg::SUM_W-1:0];
    assign n_energy_sum = energy_add[pdd_pkg::SUM_W] ? '1 : energy_add[pdd_pkg::SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_sum   <= '0;
            r_energy_sum <= '0;
        end else if (fin_go && r_disp) begin
            r_time_sum   <= n_time_sum;
            r_energy_sum <= n_energy_sum;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_out.status        <= r_status;
            r_out.dispatched    <= r_disp;
            r_out.out_task_id   <= r_task.id;
            r_out.out_priority  <= r_task.prio;
            r_out.out_burst     <= r_task.burst;
            r_out.power_mode    <= r_mode;
            r_out.exec_time     <= r_exec;
            r_out.energy        <= r_eng;
            r_out.elapsed_total <= r_disp ? n_time_sum : r_time_sum;
            r_out.energy_total  <= r_disp ? n_energy_sum : r_energy_sum;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_remove_has_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REMOVE) |-> (best.valid && (r_count != '0)))
        else $error("removal without a candidate");

    a_add_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        add_go |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("accepted add did not grow the queue");

    a_disp_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.dispatched) |-> (o_out_data.status == pdd_pkg::ST_OK))
        else $error("dispatched result with error status");

endmodule

>>> test/priority_dvfs_task_dispatcher_test.sv
`timescale 1ns / 1ps
// Self-checking bench for priority_dvfs_task_dispatcher: a task-level predictor
// mirrors the queue, power mode and totals. Depends on pdd_pkg and the RTL.
module priority_dvfs_task_dispatcher_test;

    localparam int unsigned QUEUE_DEPTH    = 16;
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          SETTLE_CYCLES  = QUEUE_DEPTH + 8;

    logic                           i_clk     = 1'b0;
    logic                           i_rst_n   = 1'b0;
    logic                           in_valid  = 1'b0;
    pdd_pkg::t_in                   in_data   = '0;
    logic                           out_ready = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [pdd_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [pdd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                           o_in_ready;
    logic                           o_out_valid;
    pdd_pkg::t_out                  o_out_data;

    // Shadow copy of the block: registers, queued tasks, mode and totals
    logic [pdd_pkg::CFG_DATA_W-1:0] settings [8];
    pdd_pkg::t_entry                waiting_tasks [$];
    logic [1:0]                     mode_now;
    logic [pdd_pkg::SUM_W-1:0]      time_sum;
    logic [pdd_pkg::SUM_W-1:0]      energy_sum;
    pdd_pkg::t_out                  expected_results [$];

    // Run bookkeeping
    int  mismatches   = 0;
    int  n_added      = 0;
    int  n_dispatched = 0;
    int  n_dropped    = 0;
    int  n_empty      = 0;
    int  quiet_cycles = 0;
    bit  idle_on      = 1'b1;
    int  hold_requested = 0;
    int  hold_served    = 0;
    int  hold_left      = 0;

    priority_dvfs_task_dispatcher #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Result of one transfer into the block; updates the shadow state
    function automatic pdd_pkg::t_out dispatch_outcome(input pdd_pkg::t_in item);
        pdd_pkg::t_out                  r;
        int                             best;
        pdd_pkg::t_entry                picked;
        logic [pdd_pkg::CFG_DATA_W-1:0] tu;
        logic [pdd_pkg::CFG_DATA_W-1:0] eu;
        logic [pdd_pkg::SUM_W:0]        acc;
        r = '0;
        if (item.action == pdd_pkg::ACT_ADD) begin
            if (waiting_tasks.size() >= QUEUE_DEPTH) begin
                r.status = pdd_pkg::ST_FULL;
                n_dropped++;
            end else begin
                picked.id    = item.task_id;
                picked.prio  = item.task_priority;
                picked.burst = item.burst_units;
                waiting_tasks.push_back(picked);
                n_added++;
            end
        end else if (waiting_tasks.size() == 0) begin
            r.status = pdd_pkg::ST_EMPTY;
            n_empty++;
        end else begin
            // lowest priority value wins, earliest arrival on a tie
            best = 0;
            for (int i = 1; i < waiting_tasks.size(); i++)
                if (waiting_tasks[i].prio < waiting_tasks[best].prio) best = i;
            picked = waiting_tasks[best];
            waiting_tasks.delete(best);
            if (picked.prio < settings[pdd_pkg::REG_HIGH_LIMIT][pdd_pkg::PRIO_W-1:0]) begin
                mode_now = pdd_pkg::MODE_HIGH;
                tu = settings[pdd_pkg::REG_TU_HIGH];
                eu = settings[pdd_pkg::REG_EU_HIGH];
            end else if (picked.prio < settings[pdd_pkg::REG_MED_LIMIT][pdd_pkg::PRIO_W-1:0]) begin
                mode_now = pdd_pkg::MODE_BALANCED;
                tu = settings[pdd_pkg::REG_TU_BAL];
                eu = settings[pdd_pkg::REG_EU_BAL];
            end else begin
                mode_now = pdd_pkg::MODE_SAVING;
                tu = settings[pdd_pkg::REG_TU_SAVE];
                eu = settings[pdd_pkg::REG_EU_SAVE];
            end
            r.exec_time = pdd_pkg::PROD_W'(picked.burst) * pdd_pkg::PROD_W'(tu);
            r.energy    = pdd_pkg::PROD_W'(picked.burst) * pdd_pkg::PROD_W'(eu);
            acc = {1'b0, time_sum} + (pdd_pkg::SUM_W + 1)'(r.exec_time);
            time_sum = acc[pdd_pkg::SUM_W] ? {pdd_pkg::SUM_W{1'b1}} : acc[pdd_pkg::SUM_W-1:0];
            acc = {1'b0, energy_sum} + (pdd_pkg::SUM_W + 1)'(r.energy);
            energy_sum = acc[pdd_pkg::SUM_W] ? {pdd_pkg::SUM_W{1'b1}} : acc[pdd_pkg::SUM_W-1:0];
            r.dispatched   = 1'b1;
            r.out_task_id  = picked.id;
            r.out_priority = picked.prio;
            r.out_burst    = picked.burst;
            n_dispatched++;
        end
        r.power_mode    = mode_now;
        r.elapsed_total = time_sum;
        r.energy_total  = energy_sum;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [pdd_pkg::SUM_W-1:0] want,
                               input logic [pdd_pkg::SUM_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Result checker: every output transfer against the oldest expectation
    always @(posedge i_clk) begin
        pdd_pkg::t_out want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %h", $time, o_out_data);
            end else begin
                want = expected_results.pop_front();
                check_field("status",        want.status,        o_out_data.status);
                check_field("dispatched",    want.dispatched,    o_out_data.dispatched);
                check_field("out_task_id",   want.out_task_id,   o_out_data.out_task_id);
                check_field("out_priority",  want.out_priority,  o_out_data.out_priority);
                check_field("out_burst",     want.out_burst,     o_out_data.out_burst);
                check_field("power_mode",    want.power_mode,    o_out_data.power_mode);
                check_field("exec_time",     want.exec_time,     o_out_data.exec_time);
                check_field("energy",        want.energy,        o_out_data.energy);
                check_field("elapsed_total", want.elapsed_total, o_out_data.elapsed_total);
                check_field("energy_total",  want.energy_total,  o_out_data.energy_total);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requested) begin
            out_ready   <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_requested;
        end else if (idle_on && $urandom_range(99) < 10) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Watchdog: too long without any transfer or register write
    always @(posedge i_clk) begin
        if (!i_rst_n || cfg_we || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one task item; returns at the edge where it transfers
    task automatic send_item(input pdd_pkg::t_in item);
        int gap;
        if (idle_on && $urandom_range(99) < 10) begin
            gap = $urandom_range(4, 1);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        expected_results.push_back(dispatch_outcome(item));
    endtask

    function automatic pdd_pkg::t_in make_item(input logic act,
                                               input logic [pdd_pkg::ID_W-1:0] id,
                                               input logic [pdd_pkg::PRIO_W-1:0] prio,
                                               input logic [pdd_pkg::BURST_W-1:0] burst);
        pdd_pkg::t_in it;
        it.action        = act;
        it.task_id       = id;
        it.task_priority = prio;
        it.burst_units   = burst;
        return it;
    endfunction

    // Stop offering and wait until every result has been taken
    task automatic drain;
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all eight registers back to back; only while the block is idle
    task automatic apply_settings(input logic [pdd_pkg::CFG_DATA_W-1:0] vals [8]);
        for (int i = 0; i < 8; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= i[pdd_pkg::CFG_IDX_W-1:0];
            cfg_data <= vals[i];
            @(posedge i_clk);
            settings[i] = vals[i];
            if (i[pdd_pkg::CFG_IDX_W-1:0] == pdd_pkg::REG_HIGH_LIMIT ||
                i[pdd_pkg::CFG_IDX_W-1:0] == pdd_pkg::REG_MED_LIMIT)
                settings[i] = {16'h0, vals[i][pdd_pkg::PRIO_W-1:0]};
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [pdd_pkg::CFG_DATA_W-1:0] random_unit;
        case ($urandom_range(5))
            0:       return '0;
            1:       return {pdd_pkg::CFG_DATA_W{1'b1}};
            default: return pdd_pkg::CFG_DATA_W'($urandom);
        endcase
    endfunction

    // Random item; priorities often drawn from a narrow range to force ties
    function automatic pdd_pkg::t_in random_task(input int add_pct, input bit long_bursts);
        pdd_pkg::t_in it;
        it.action        = ($urandom_range(99) < add_pct) ? pdd_pkg::ACT_ADD
                                                          : pdd_pkg::ACT_DISPATCH;
        it.task_id       = pdd_pkg::ID_W'($urandom);
        it.task_priority = pdd_pkg::PRIO_W'($urandom_range(1) ? $urandom_range(7)
                                                              : $urandom_range(255));
        if (long_bursts && $urandom_range(9) != 0)
            it.burst_units = {pdd_pkg::BURST_W{1'b1}};
        else if ($urandom_range(9) == 0)
            it.burst_units = $urandom_range(1) ? '0 : {pdd_pkg::BURST_W{1'b1}};
        else
            it.burst_units = pdd_pkg::BURST_W'($urandom);
        return it;
    endfunction

    // Mixed traffic in blocks that lean toward filling, then emptying the queue
    task automatic run_traffic(input int count, input bit long_bursts);
        int add_pct;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(9) == 0) add_pct = 50;
            else add_pct = ((n / 40) % 2 == 0) ? 75 : 30;
            send_item(random_task(add_pct, long_bursts));
        end
    endtask

    // Reset values: empty dispatch, field extremes, ties, thresholds, full queue
    task automatic test_directed_queue;
        send_item(make_item(pdd_pkg::ACT_DISPATCH, 16'h0, 8'h0, 16'h0));
        send_item(make_item(pdd_pkg::ACT_ADD, 16'hFFFF, 8'hFF, 16'hFFFF));
        send_item(make_item(pdd_pkg::ACT_ADD, 16'h0000, 8'h00, 16'h0000));
        send_item(make_item(pdd_pkg::ACT_ADD, 16'h1111, 8'h01, 16'h0001));
        send_item(make_item(pdd_pkg::ACT_ADD, 16'h2222, 8'h02, 16'h8000));
        send_item(make_item(pdd_pkg::ACT_ADD, 16'h3333, 8'h02, 16'h0100));
        send_item(make_item(pdd_pkg::ACT_ADD, 16'h4444, 8'h04, 16'h00FF));
        send_item(make_item(pdd_pkg::ACT_ADD, 16'h5555, 8'h05, 16'hFFFF));
        for (int i = 0; i < 9; i++)
            send_item(make_item(pdd_pkg::ACT_ADD, pdd_pkg::ID_W'(16'h7000 + i),
                                pdd_pkg::PRIO_W'(8'h40 + 16 * i),
                                pdd_pkg::BURST_W'(16'h1234 * (i + 1))));
        // queue holds sixteen now, this one is dropped
        send_item(make_item(pdd_pkg::ACT_ADD, 16'hAAAA, 8'h00, 16'hAAAA));
        repeat (6) send_item(make_item(pdd_pkg::ACT_DISPATCH, 16'hFFFF, 8'hFF, 16'hFFFF));
        drain();
    endtask

    // Threshold extremes and out-of-order limits, each with random traffic
    task automatic test_threshold_settings;
        logic [pdd_pkg::CFG_DATA_W-1:0] vals [8];
        for (int phase = 0; phase < 5; phase++) begin
            for (int i = 0; i < 8; i++) vals[i] = random_unit();
            case (phase)
                0: begin    // nothing below either limit: saving only, zero units
                    vals[pdd_pkg::REG_HIGH_LIMIT] = 24'hFFFF00;
                    vals[pdd_pkg::REG_MED_LIMIT]  = 24'h000000;
                    for (int i = pdd_pkg::REG_TU_HIGH; i <= pdd_pkg::REG_EU_SAVE; i++)
                        vals[i] = '0;
                end
                1: begin    // everything but 255 is high performance, full units
                    vals[pdd_pkg::REG_HIGH_LIMIT] = 24'h0000FF;
                    vals[pdd_pkg::REG_MED_LIMIT]  = 24'hABCDFF;
                    for (int i = pdd_pkg::REG_TU_HIGH; i <= pdd_pkg::REG_EU_SAVE; i++)
                        vals[i] = '1;
                end
                2: begin    // limits out of order, balanced never chosen
                    vals[pdd_pkg::REG_HIGH_LIMIT] = 24'h000004;
                    vals[pdd_pkg::REG_MED_LIMIT]  = 24'h000002;
                end
                3: begin    // balanced for all but 255
                    vals[pdd_pkg::REG_HIGH_LIMIT] = 24'h000000;
                    vals[pdd_pkg::REG_MED_LIMIT]  = 24'h0000FF;
                end
                default: begin
                    vals[pdd_pkg::REG_HIGH_LIMIT] = pdd_pkg::CFG_DATA_W'($urandom_range(6));
                    vals[pdd_pkg::REG_MED_LIMIT]  = pdd_pkg::CFG_DATA_W'($urandom_range(8));
                end
            endcase
            apply_settings(vals);
            run_traffic(80, 1'b0);
            drain();
        end
    endtask

    // Receiver stalls for a long stretch while items keep coming
    task automatic test_output_backpressure;
        hold_requested <= hold_requested + 1;
        run_traffic(40, 1'b0);
        drain();
    endtask

    // Full units and long bursts until both totals stick at their maximum
    task automatic test_total_saturation;
        logic [pdd_pkg::CFG_DATA_W-1:0] vals [8];
        for (int i = 0; i < 8; i++) vals[i] = '1;
        vals[pdd_pkg::REG_HIGH_LIMIT] = pdd_pkg::CFG_DATA_W'($urandom_range(255));
        vals[pdd_pkg::REG_MED_LIMIT]  = pdd_pkg::CFG_DATA_W'($urandom_range(255));
        idle_on = 1'b0;
        apply_settings(vals);
        for (int n = 0; n < 640; n++) send_item(random_task(55, 1'b1));
        drain();
        idle_on = 1'b1;
    endtask

    initial begin
        settings[pdd_pkg::REG_HIGH_LIMIT] = 24'd2;
        settings[pdd_pkg::REG_MED_LIMIT]  = 24'd5;
        settings[pdd_pkg::REG_TU_HIGH]    = 24'd26214;
        settings[pdd_pkg::REG_TU_BAL]     = 24'd43691;
        settings[pdd_pkg::REG_TU_SAVE]    = 24'd81920;
        settings[pdd_pkg::REG_EU_HIGH]    = 24'd131072;
        settings[pdd_pkg::REG_EU_BAL]     = 24'd131072;
        settings[pdd_pkg::REG_EU_SAVE]    = 24'd122880;
        mode_now   = pdd_pkg::MODE_BALANCED;
        time_sum   = '0;
        energy_sum = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_queue();
        test_threshold_settings();
        test_output_backpressure();
        test_total_saturation();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            mismatches += expected_results.size();
            $display("%0t: %0d results never arrived", $time, expected_results.size());
        end
        $display("Covered %0d adds, %0d dispatches, %0d dropped on full, %0d empty dispatches,",
                 n_added, n_dispatched, n_dropped, n_empty);
        $display("threshold extremes, receiver hold-off; totals saturated: %0b/%0b",
                 &time_sum, &energy_sum);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> priority_dvfs_task_dispatcher.f
rtl/pdd_pkg.sv
rtl/pdd_cell.sv
rtl/priority_dvfs_task_dispatcher.sv
test/priority_dvfs_task_dispatcher_test.sv
